// ===== rtl/core/mouse_click_chatter_filter_top_defines.svh =====
// Assertion helpers shared by the chatter filter RTL.
`ifndef MOUSE_CLICK_CHATTER_FILTER_TOP_DEFINES_SVH
`define MOUSE_CLICK_CHATTER_FILTER_TOP_DEFINES_SVH

// Check on every clock edge outside reset.
`define MCCF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define MCCF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/mccf_pkg.sv =====
package mccf_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int TIME_BITS   = 32;
  localparam int BTN_W       = 2;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(45);
  localparam logic [CFG_W-1:0] LEEWAY_RST   = CFG_W'(60);

  localparam logic CMD_PRESS   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEBOUNCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LEEWAY   = CFG_IDX_W'(1);

  typedef struct packed {
    logic [TIME_BITS-1:0] last_press;
    logic [TIME_BITS-1:0] last_release;
    logic [TIME_BITS-1:0] last_blocked_gap;
    logic                 was_blocked;
    logic                 pass_armed;
    logic                 seen_press;
  } btn_state_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] hold;
    logic [TIME_BITS-1:0] release_gap;
    logic [TIME_BITS-1:0] press_gap;
    logic                 first_press;
    logic                 blocked;
  } result_t;

endpackage

// ===== rtl/core/mccf_eval.sv =====
module mccf_eval (
  input  logic                          cmd,
  input  logic [mccf_pkg::TIME_BITS-1:0] ts,
  input  logic [mccf_pkg::CFG_W-1:0]    debounce,
  input  logic [mccf_pkg::CFG_W-1:0]    leeway,
  input  mccf_pkg::btn_state_t          st,
  output mccf_pkg::btn_state_t          st_nxt,
  output mccf_pkg::result_t             res
);
  import mccf_pkg::*;

  logic [TIME_BITS-1:0] since_press;
  logic [TIME_BITS-1:0] since_release;
  logic [TIME_BITS:0]   gap_sum;
  logic                 over_leeway;
  logic                 armed;
  logic                 block;

  assign since_press   = ts - st.last_press;
  assign since_release = ts - st.last_release;
  // one extra bit keeps the two-gap sum from wrapping
  assign gap_sum     = {1'b0, st.last_blocked_gap} + {1'b0, since_press};
  assign over_leeway = gap_sum > (TIME_BITS+1)'(leeway);
  assign armed       = st.pass_armed && !(st.was_blocked && over_leeway);
  assign block       = armed && (since_press <= TIME_BITS'(debounce));

  always_comb begin
    st_nxt = st;
    res    = '0;
    case (cmd)
      CMD_PRESS: begin
        res.blocked     = block;
        res.first_press = !st.seen_press;
        res.press_gap   = since_press;
        res.release_gap = since_release;
        st_nxt.seen_press  = 1'b1;
        st_nxt.pass_armed  = armed;
        st_nxt.was_blocked = block;
        st_nxt.last_press  = ts;
        if (block) begin
          st_nxt.last_blocked_gap = since_press;
        end
      end
      CMD_RELEASE: begin
        res.hold            = since_press;
        st_nxt.last_release = ts;
        st_nxt.pass_armed   = 1'b1;
      end
      default: begin
        st_nxt = st;
      end
    endcase
  end

endmodule

// ===== rtl/core/mouse_click_chatter_filter_top.sv =====
// Mouse button chatter filter.
// Input stream: one beat per button event. in_tuser carries the event kind
// and the button number, in_tdata the event time in ms. Each accepted beat
// for a valid button gives one output beat: the blocked and first-press
// flags in out_tuser, and the press gap, release gap and hold time in
// out_tdata. Beats naming a button number past the last button are taken
// and dropped without a result or any change of state.
// The result is registered: it appears in the cycle after the input beat is taken.
// Throughput: one event per cycle while the output is not stalled; the
// per-button read-modify-write of the timing registers completes in the cycle of acceptance.
// A stalled output holds its beat; a new input is taken in the same cycle
// that the waiting beat leaves, so the pipeline never bubbles.
// The cfg port writes the debounce and leeway limits; write only while no
// beat is in flight.
// Reset (rst_n low, synchronous) clears all button state, empties the
// output register and restores the limits to 45 ms and 60 ms.
`include "mouse_click_chatter_filter_top_defines.svh"

module mouse_click_chatter_filter_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [31:0]                      in_tdata,  // [31:0] timestamp_ms
  input  logic [7:0]                       in_tuser,  // [0] cmd, [2:1] button
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [95:0]                      out_tdata, // [31:0] press_gap_ms,
                                                      // [63:32] release_gap_ms,
                                                      // [95:64] hold_ms
  output logic [7:0]                       out_tuser, // [0] blocked, [1] first_press
  input  logic                             cfg_we,
  input  logic [mccf_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [mccf_pkg::CFG_W-1:0]       cfg_wdata
);
  import mccf_pkg::*;

  btn_state_t           st_r [NUM_BUTTONS];
  btn_state_t           sel_st;
  btn_state_t           st_nxt;
  result_t              res;
  result_t              res_r;
  logic                 out_valid_r;
  logic [CFG_W-1:0]     debounce_r;
  logic [CFG_W-1:0]     leeway_r;
  logic [BTN_W-1:0]     btn;
  logic                 cmd;
  logic [TIME_BITS-1:0] ts;
  logic                 btn_ok;
  logic                 in_acc;

  assign cmd       = in_tuser[0];
  assign btn       = in_tuser[BTN_W:1];
  assign ts        = in_tdata[TIME_BITS-1:0];
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    sel_st = '0;
    btn_ok = 1'b0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      if (btn == BTN_W'(i)) begin
        sel_st = st_r[i];
        btn_ok = 1'b1;
      end
    end
  end

  mccf_eval u_eval (
    .cmd      (cmd),
    .ts       (ts),
    .debounce (debounce_r),
    .leeway   (leeway_r),
    .st       (sel_st),
    .st_nxt   (st_nxt),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        st_r[i] <= '0;
      end
    end else if (in_acc && btn_ok) begin
      for (int i = 0; i < NUM_BUTTONS; i++) begin
        if (btn == BTN_W'(i)) begin
          st_r[i] <= st_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DEBOUNCE_RST;
      leeway_r   <= LEEWAY_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_IDX_DEBOUNCE: debounce_r <= cfg_wdata;
        CFG_IDX_LEEWAY:   leeway_r   <= cfg_wdata;
        default: begin
          debounce_r <= debounce_r;
        end
      endcase
    end
  end

  // advance the output beat; drop events for absent buttons
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_acc && btn_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.hold, res_r.release_gap, res_r.press_gap};
  assign out_tuser  = {6'b0, res_r.first_press, res_r.blocked};

  `MCCF_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid after reset")
  `MCCF_ASSERT(a_drop_oob, (in_tready && !(in_acc && btn_ok)) |=> !out_tvalid,
    "result for dropped event")
  `MCCF_ASSERT(a_kind_fields, out_tvalid |-> (res_r.hold == '0) ||
    (out_tuser == '0 && res_r.press_gap == '0 && res_r.release_gap == '0),
    "press and release fields mixed")
  `MCCF_ASSERT(a_block_limit, (out_tvalid && res_r.blocked) |->
    (res_r.press_gap <= TIME_BITS'(debounce_r)), "blocked press above debounce limit")

endmodule
